// ===== hw/rtl/depth_outlier_neighbour_filter_unit_macros.svh =====
// Assertion macros shared by the outlier filter RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef DEPTH_OUTLIER_NEIGHBOUR_FILTER_UNIT_MACROS_SVH
`define DEPTH_OUTLIER_NEIGHBOUR_FILTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DONF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DONF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/donf_pkg.sv =====
// Shared types and constants for the depth outlier neighbour filter.
// No dependencies; imported by donf_line_buf and the top level.
`timescale 1ns / 1ps

package donf_pkg;

   localparam int FIELD_BITS        = 16;
   localparam int CSR_DATA_BITS     = 16;
   localparam int IMAGE_WIDTH_BITS  = 13;
   localparam int IMAGE_HEIGHT_BITS = 16;
   localparam int ROW_BITS          = 16;

   localparam logic [IMAGE_WIDTH_BITS-1:0]  IMAGE_WIDTH_RESET  = 13'd4096;
   localparam logic [IMAGE_HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET = 16'd4096;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Line buffer strobes issued by the filter pipeline
   typedef struct packed {
      logic rd_en;
      logic cur_we;
      logic above_we;
   } lb_ctrl_type;

endpackage

// ===== hw/rtl/depth_outlier_neighbour_filter_unit.sv =====
// Depth outlier neighbour filter, top level.
//
// Request channel (req_*): valid/ready. Each request is either a depth pixel in
// raster order or a flush. A pixel of row n yields the corrected pixel of row
// n-1 at the same column; row 0 yields nothing, pixels beyond the last row are
// dropped. Each flush yields one pixel of the final row; the final one has
// rsp_last set and restarts the image.
// Response channel (rsp_*): valid/ready, depth_out, replaced and last.
// Configuration (csr_*): write enable, index, data; width at index 0, height at
// index 1. Any write restarts the image. Write only while the block is idle.
// Throughput: one request per cycle while req_ready is high. The line buffers
// are read as a request enters the compute stage; the output register loads
// when that stage advances, which a stalled response can hold off. Rate is set
// by the single read-modify-write of the line buffers per pixel.
// A stalled response holds in the output register; the compute stage keeps
// accepting work that produces no response and otherwise waits, so req_ready
// drops only when both the output register and the compute stage are full.
// Reset clears counters and restores width and height to 4096; line buffers
// are not cleared and need no sweep.
`timescale 1ns / 1ps
`include "depth_outlier_neighbour_filter_unit_macros.svh"

module depth_outlier_neighbour_filter_unit import donf_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int DEPTH_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [FIELD_BITS-1:0]    req_depth_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [FIELD_BITS-1:0]    rsp_depth_out,
   output logic                     rsp_replaced,
   output logic                     rsp_last,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int CW = (XW >= IMAGE_WIDTH_BITS) ? XW + 1 : IMAGE_WIDTH_BITS + 1;

   // configuration
   logic [IMAGE_WIDTH_BITS-1:0]  image_width_ff;
   logic [IMAGE_HEIGHT_BITS-1:0] image_height_ff;
   logic [CW-1:0]                width_ext;
   logic [XW-1:0]                eff_w_m1;
   logic [ROW_BITS-1:0]          eff_h;

   // position counters
   logic [XW-1:0]         column_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic [XW-1:0]         flush_ff;
   logic [DEPTH_BITS-1:0] left_final_ff;

   // accept decode
   logic req_accept;
   logic is_pixel;
   logic in_image;
   logic at_row_end;
   logic flush_fin;
   logic s1_load;

   // compute stage
   logic                  s1_valid_ff;
   logic                  s1_flush_ff;
   logic                  s1_emit_ff;
   logic                  s1_interior_ff;
   logic                  s1_fin_ff;
   logic [XW-1:0]         s1_x_ff;
   logic [DEPTH_BITS-1:0] s1_d_ff;
   logic                  s1_adv;

   // line buffer
   lb_ctrl_type           lb_ctrl;
   logic [XW-1:0]         rd_addr;
   logic [DEPTH_BITS-1:0] cur_q;
   logic [DEPTH_BITS-1:0] right_q;
   logic [DEPTH_BITS-1:0] above_q;

   // outlier test
   logic                  higher;
   logic                  lower;
   logic                  outlier;
   logic [DEPTH_BITS+1:0] sum;
   logic [DEPTH_BITS-1:0] result;

   // output register
   logic                  rsp_valid_ff;
   logic [DEPTH_BITS-1:0] rsp_depth_ff;
   logic                  rsp_replaced_ff;
   logic                  rsp_last_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == REG_IMAGE_WIDTH) begin
            image_width_ff <= csr_write_data[IMAGE_WIDTH_BITS-1:0];
         end else begin
            image_height_ff <= csr_write_data[IMAGE_HEIGHT_BITS-1:0];
         end
      end
   end

   assign width_ext = CW'(image_width_ff);

   always_comb begin
      if (width_ext == '0) begin
         eff_w_m1 = '0;
      end else if (width_ext > CW'(MAX_WIDTH)) begin
         eff_w_m1 = XW'(MAX_WIDTH - 1);
      end else begin
         eff_w_m1 = XW'(width_ext - 1'b1);
      end
   end

   assign eff_h = (image_height_ff == '0) ? ROW_BITS'(1) : image_height_ff;

   // ---------------------------------------------------------------- accept
   assign req_accept = req_valid && req_ready;
   assign is_pixel   = (req_operation == OP_PIXEL);
   assign in_image   = (row_ff < eff_h);
   assign at_row_end = (column_ff == eff_w_m1);
   assign flush_fin  = (flush_ff == eff_w_m1);
   assign s1_load    = req_accept && (!is_pixel || in_image);

   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         column_ff <= '0;
         row_ff    <= '0;
         flush_ff  <= '0;
      end else if (req_accept) begin
         if (!is_pixel) begin
            if (flush_fin) begin
               column_ff <= '0;
               row_ff    <= '0;
               flush_ff  <= '0;
            end else begin
               flush_ff <= flush_ff + 1'b1;
            end
         end else if (in_image) begin
            if (at_row_end) begin
               column_ff <= '0;
               row_ff    <= row_ff + 1'b1;
            end else begin
               column_ff <= column_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_flush_ff    <= !is_pixel;
         s1_emit_ff     <= !is_pixel || (row_ff != '0);
         s1_interior_ff <= is_pixel && (row_ff >= ROW_BITS'(2)) &&
                           (column_ff != '0) && !at_row_end;
         s1_fin_ff      <= !is_pixel && flush_fin;
         s1_x_ff        <= column_ff;
         s1_d_ff        <= req_depth_in[DEPTH_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- line buffer
   assign rd_addr          = is_pixel ? column_ff : flush_ff;
   assign lb_ctrl.rd_en    = s1_load;
   assign lb_ctrl.cur_we   = s1_adv && !s1_flush_ff;
   assign lb_ctrl.above_we = s1_adv && !s1_flush_ff && s1_emit_ff;

   donf_line_buf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_line_buf (
      .clock       (clock),
      .ctrl        (lb_ctrl),
      .rd_addr     (rd_addr),
      .wr_addr     (s1_x_ff),
      .cur_wdata   (s1_d_ff),
      .above_wdata (result),
      .cur_q       (cur_q),
      .right_q     (right_q),
      .above_q     (above_q)
   );

   // ---------------------------------------------------------------- compute
   // top and left are corrected values, right and bottom are originals
   assign higher = (cur_q > above_q) && (cur_q > s1_d_ff) &&
                   (cur_q > left_final_ff) && (cur_q > right_q);
   assign lower  = (cur_q < above_q) && (cur_q < s1_d_ff) &&
                   (cur_q < left_final_ff) && (cur_q < right_q);
   assign outlier = s1_interior_ff && (higher || lower);

   assign sum = (DEPTH_BITS+2)'(above_q) + (DEPTH_BITS+2)'(s1_d_ff) +
                (DEPTH_BITS+2)'(left_final_ff) + (DEPTH_BITS+2)'(right_q) +
                (DEPTH_BITS+2)'(2);
   assign result = outlier ? sum[DEPTH_BITS+1:2] : cur_q;

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         left_final_ff <= '0;
      end else if (s1_adv) begin
         if (s1_fin_ff) begin
            left_final_ff <= '0;
         end else if (!s1_flush_ff && s1_emit_ff) begin
            left_final_ff <= result;
         end
      end
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_depth_ff    <= result;
         rsp_replaced_ff <= outlier;
         rsp_last_ff     <= s1_fin_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_depth_out = FIELD_BITS'(rsp_depth_ff);
   assign rsp_replaced  = rsp_replaced_ff;
   assign rsp_last      = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   `DONF_ASSERT_SAME(a_last_not_replaced, rsp_valid && rsp_last, !rsp_replaced, "final pixel flagged as replaced")
   `DONF_ASSERT_SAME(a_column_in_row, 1'b1, (column_ff <= eff_w_m1) && (flush_ff <= eff_w_m1), "column counter beyond row width")
   `DONF_ASSERT_NEXT(a_fin_restarts, req_accept && !is_pixel && flush_fin, (column_ff == '0) && (row_ff == '0) && (flush_ff == '0), "counters not cleared after final flush")

endmodule

// ===== hw/rtl/donf_line_buf.sv =====
// Line buffers of the outlier filter: original pending row and corrected row above.
// Depends on donf_pkg for the control struct.
`timescale 1ns / 1ps

module donf_line_buf import donf_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int DEPTH_BITS = 16,
   localparam int XW = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  lb_ctrl_type           ctrl,
   input  logic [XW-1:0]         rd_addr,
   input  logic [XW-1:0]         wr_addr,
   input  logic [DEPTH_BITS-1:0] cur_wdata,
   input  logic [DEPTH_BITS-1:0] above_wdata,
   output logic [DEPTH_BITS-1:0] cur_q,
   output logic [DEPTH_BITS-1:0] right_q,
   output logic [DEPTH_BITS-1:0] above_q
);

   logic [DEPTH_BITS-1:0] cur_mem   [MAX_WIDTH];
   logic [DEPTH_BITS-1:0] above_mem [MAX_WIDTH];

   logic [XW-1:0]         rd_addr_right;
   logic [DEPTH_BITS-1:0] cur_rd_ff;
   logic [DEPTH_BITS-1:0] right_rd_ff;
   logic [DEPTH_BITS-1:0] above_rd_ff;
   logic                  fwd_ff;
   logic [DEPTH_BITS-1:0] fwd_data_ff;

   assign rd_addr_right = rd_addr + 1'b1;

   always_ff @(posedge clock) begin
      if (ctrl.cur_we) begin
         cur_mem[wr_addr] <= cur_wdata;
      end
      if (ctrl.above_we) begin
         above_mem[wr_addr] <= above_wdata;
      end
      if (ctrl.rd_en) begin
         cur_rd_ff   <= cur_mem[rd_addr];
         right_rd_ff <= cur_mem[rd_addr_right];
         above_rd_ff <= above_mem[rd_addr];
         // a write to the same entry in this cycle is not yet in the array
         fwd_ff      <= ctrl.cur_we && (wr_addr == rd_addr);
         fwd_data_ff <= cur_wdata;
      end
   end

   assign cur_q   = fwd_ff ? fwd_data_ff : cur_rd_ff;
   assign right_q = right_rd_ff;
   assign above_q = above_rd_ff;

endmodule

// ===== tb/donf_outlier_prediction_check.sv =====
// Prediction and response checking for the depth outlier neighbour filter.
// Watches the request, response and CSR ports; depends on donf_pkg only.
`timescale 1ns / 1ps

module donf_outlier_prediction_check import donf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_operation,
   input  logic [FIELD_BITS-1:0]    req_depth_in,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [FIELD_BITS-1:0]    rsp_depth_out,
   input  logic                     rsp_replaced,
   input  logic                     rsp_last,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   output int                       fail_count,
   output int                       pending_count
);

   localparam int LINE_LEN = 4096;

   typedef struct packed {
      logic [FIELD_BITS-1:0] depth;
      logic                  replaced;
      logic                  last;
   } filtered_pixel_type;

   filtered_pixel_type           expected_pixels[$];
   logic [FIELD_BITS-1:0]        corrected_above[LINE_LEN];
   logic [FIELD_BITS-1:0]        original_pending[LINE_LEN];
   logic [FIELD_BITS-1:0]        left_corrected;
   logic [IMAGE_WIDTH_BITS-1:0]  width_setting;
   logic [IMAGE_HEIGHT_BITS-1:0] height_setting;
   int                           next_col;
   int                           next_row;
   int                           flush_col;
   int                           mismatches;

   function automatic int active_width();
      if (width_setting == '0)
         return 1;
      if (width_setting > LINE_LEN)
         return LINE_LEN;
      return int'(width_setting);
   endfunction

   task automatic restart_image();
      left_corrected = '0;
      next_col       = 0;
      next_row       = 0;
      flush_col      = 0;
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic queue_expected(input filtered_pixel_type px);
      expected_pixels.insert(expected_pixels.size(), px);
   endtask

   task automatic predict_request(input logic op, input logic [FIELD_BITS-1:0] d);
      int w;
      int h;
      int x;
      int c;
      int t;
      int l;
      int r;
      int b;
      filtered_pixel_type px;
      w = active_width();
      h = (height_setting == '0) ? 1 : int'(height_setting);
      if (op_type'(op) == OP_FLUSH) begin
         x = (flush_col >= w) ? w - 1 : flush_col;
         px.depth    = original_pending[x];
         px.replaced = 1'b0;
         px.last     = (x == w - 1);
         queue_expected(px);
         if (px.last)
            restart_image();
         else
            flush_col = x + 1;
      end else if (next_row < h) begin
         x = (next_col >= w) ? w - 1 : next_col;
         if (next_row >= 1) begin
            c           = int'(original_pending[x]);
            px.depth    = original_pending[x];
            px.replaced = 1'b0;
            px.last     = 1'b0;
            // interior only: top from the corrected row, bottom is this request
            if (next_row >= 2 && x >= 1 && x + 1 < w) begin
               t = int'(corrected_above[x]);
               l = int'(left_corrected);
               r = int'(original_pending[x + 1]);
               b = int'(d);
               if ((c > t && c > b && c > l && c > r) ||
                   (c < t && c < b && c < l && c < r)) begin
                  px.depth    = FIELD_BITS'((t + b + l + r + 2) / 4);
                  px.replaced = 1'b1;
               end
            end
            corrected_above[x] = px.depth;
            left_corrected     = px.depth;
            queue_expected(px);
         end
         original_pending[x] = d;
         next_col = x + 1;
         if (next_col >= w) begin
            next_col = 0;
            next_row++;
         end
      end
   endtask

   task automatic compare_response();
      filtered_pixel_type px;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("response depth %0d with nothing expected", rsp_depth_out));
      end else begin
         px = expected_pixels.pop_front();
         if (rsp_depth_out !== px.depth)
            report_mismatch($sformatf("depth_out %0d, expected %0d", rsp_depth_out, px.depth));
         if (rsp_replaced !== px.replaced)
            report_mismatch($sformatf("replaced %b, expected %b", rsp_replaced, px.replaced));
         if (rsp_last !== px.last)
            report_mismatch($sformatf("last %b, expected %b", rsp_last, px.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_setting  = IMAGE_WIDTH_RESET;
         height_setting = IMAGE_HEIGHT_RESET;
         restart_image();
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               REG_IMAGE_WIDTH:  width_setting  = csr_write_data[IMAGE_WIDTH_BITS-1:0];
               REG_IMAGE_HEIGHT: height_setting = csr_write_data[IMAGE_HEIGHT_BITS-1:0];
               default: ;
            endcase
            restart_image();
         end
         // check before predicting, so a stray response never meets this request
         if (rsp_valid && rsp_ready)
            compare_response();
         if (req_valid && req_ready)
            predict_request(req_operation, req_depth_in);
      end
      fail_count    <= mismatches;
      pending_count <= expected_pixels.size();
   end

endmodule

// ===== tb/tb_depth_outlier_neighbour_filter_unit.sv =====
// Testbench top for the depth outlier neighbour filter: clock, reset, stimulus, verdict.
// Needs donf_pkg, the filter RTL and donf_outlier_prediction_check.
`timescale 1ns / 1ps

module tb_depth_outlier_neighbour_filter_unit import donf_pkg::*; ();

   typedef enum int {
      DEPTH_NOISY,
      DEPTH_RANDOM,
      DEPTH_EXTREME
   } depth_style_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_operation;
   logic [FIELD_BITS-1:0]    req_depth_in;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [FIELD_BITS-1:0]    rsp_depth_out;
   logic                     rsp_replaced;
   logic                     rsp_last;
   logic                     csr_write_enable;
   logic                     csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;
   int                       fail_count;
   int                       pending_count;

   logic                     idle_on;
   depth_style_type          pixel_style;
   logic [FIELD_BITS-1:0]    pixel_level;
   int                       requests_sent;

   always #2 clock = ~clock;

   depth_outlier_neighbour_filter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_depth_in     (req_depth_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_depth_out    (rsp_depth_out),
      .rsp_replaced     (rsp_replaced),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   donf_outlier_prediction_check prediction_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_depth_in     (req_depth_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_depth_out    (rsp_depth_out),
      .rsp_replaced     (rsp_replaced),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   function automatic logic [FIELD_BITS-1:0] next_depth();
      int v;
      case (pixel_style)
         DEPTH_RANDOM:
            return FIELD_BITS'($urandom());
         DEPTH_EXTREME:
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return '1;
               default: return FIELD_BITS'($urandom());
            endcase
         default: begin
            v = int'(pixel_level) + int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 5) == 0) begin
               if ($urandom_range(0, 1) != 0)
                  v = v + int'($urandom_range(16, 30000));
               else
                  v = v - int'($urandom_range(16, 30000));
            end
            if (v < 0)
               v = 0;
            if (v > 65535)
               v = 65535;
            return FIELD_BITS'(v);
         end
      endcase
   endfunction

   // Hold valid and payload until the request is taken.
   task automatic issue_request(input op_type op, input logic [FIELD_BITS-1:0] depth);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_depth_in  <= depth;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Wait for every expected response, then let any result-free request clear the pipe.
   task automatic drain_filter();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_register(input csr_index_type idx,
                                   input logic [CSR_DATA_BITS-1:0] data);
      drain_filter();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic stream_image(input int w, input int rows, input int extra,
                               input int flushes, input bit mid_flush);
      int i;
      for (i = 0; i < rows * w; i++) begin
         if (mid_flush && $urandom_range(0, 7) == 0)
            issue_request(OP_FLUSH, FIELD_BITS'($urandom()));
         issue_request(OP_PIXEL, next_depth());
      end
      repeat (extra) issue_request(OP_PIXEL, next_depth());
      repeat (flushes) issue_request(OP_FLUSH, FIELD_BITS'($urandom()));
   endtask

   // Slow the response side in bursts.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #4_000_000;
      $display("FAIL depth_outlier_neighbour_filter_unit");
      $finish;
   end

   initial begin
      int  i;
      int  random_start;
      int  w_set;
      int  h_set;
      int  cur_w;
      int  cur_h;
      int  roll;
      int  sel;
      bit  need_config;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= OP_PIXEL;
      req_depth_in     <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_IMAGE_WIDTH;
      csr_write_data   <= '0;
      idle_on          <= 1'b1;
      pixel_style       = DEPTH_RANDOM;
      pixel_level       = '0;
      requests_sent     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // first row under reset geometry: stored only, nothing comes back
      issue_request(OP_PIXEL, 16'hFFFF);
      issue_request(OP_PIXEL, 16'h0000);

      // 3x3: one interior pixel, a high outlier then a low one
      program_register(REG_IMAGE_WIDTH, 16'd3);
      program_register(REG_IMAGE_HEIGHT, 16'd3);
      for (i = 0; i < 9; i++)
         issue_request(OP_PIXEL, (i == 4) ? 16'hFFFF : 16'h0000);
      issue_request(OP_PIXEL, 16'h1234);   // past the last row, dropped
      repeat (3) issue_request(OP_FLUSH, FIELD_BITS'($urandom()));
      for (i = 0; i < 9; i++)
         issue_request(OP_PIXEL, (i == 4) ? 16'h0000 : 16'hFFFF);
      repeat (3) issue_request(OP_FLUSH, FIELD_BITS'($urandom()));

      // zero width and height behave as one
      program_register(REG_IMAGE_WIDTH, 16'd0);
      program_register(REG_IMAGE_HEIGHT, 16'd0);
      issue_request(OP_PIXEL, 16'hA5A5);
      issue_request(OP_PIXEL, 16'h5A5A);
      issue_request(OP_FLUSH, 16'hFFFF);

      // one column, tallest image, cut short by the flush
      program_register(REG_IMAGE_WIDTH, 16'd1);
      program_register(REG_IMAGE_HEIGHT, 16'hFFFF);
      repeat (6) issue_request(OP_PIXEL, next_depth());
      issue_request(OP_FLUSH, 16'h0000);

      // widest random row; afterwards every column a random image reaches is written
      program_register(REG_IMAGE_WIDTH, 16'd64);
      program_register(REG_IMAGE_HEIGHT, 16'd2);
      stream_image(64, 2, 0, 64, 1'b0);

      // oversized width clamps to the line length
      program_register(REG_IMAGE_WIDTH, 16'hFFFF);
      program_register(REG_IMAGE_HEIGHT, 16'hFFFF);
      repeat (5) issue_request(OP_PIXEL, next_depth());
      repeat (3) issue_request(OP_FLUSH, FIELD_BITS'($urandom()));

      random_start = requests_sent;
      need_config  = 1'b1;
      cur_w        = 1;
      cur_h        = 1;
      while (requests_sent < random_start + 920) begin
         if (idle_on && requests_sent > random_start + 760)
            idle_on <= 1'b0;
         if (need_config || $urandom_range(0, 3) == 0) begin
            roll = $urandom_range(0, 19);
            if (roll < 13)
               w_set = $urandom_range(3, 8);
            else if (roll < 16)
               w_set = $urandom_range(1, 2);
            else if (roll < 19)
               w_set = $urandom_range(9, 40);
            else
               w_set = $urandom_range(41, 64);
            h_set = (w_set > 16) ? $urandom_range(1, 3) : $urandom_range(0, 6);
            sel = need_config ? 2 : $urandom_range(0, 2);
            if (sel != 1) begin
               program_register(REG_IMAGE_WIDTH, CSR_DATA_BITS'(w_set));
               cur_w = w_set;
            end
            if (sel != 0) begin
               program_register(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(h_set));
               cur_h = (h_set == 0) ? 1 : h_set;
            end
            need_config = 1'b0;
         end
         roll = $urandom_range(0, 19);
         pixel_style = (roll < 12) ? DEPTH_NOISY : (roll < 17) ? DEPTH_RANDOM : DEPTH_EXTREME;
         pixel_level = FIELD_BITS'($urandom());
         roll = $urandom_range(0, 9);
         if (roll < 7) begin
            stream_image(cur_w, cur_h, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                         cur_w, 1'b0);
         end else if (roll == 7) begin
            // truncated image, restart by a register write
            repeat ($urandom_range(1, cur_w * cur_h)) issue_request(OP_PIXEL, next_depth());
            repeat ($urandom_range(0, 2)) issue_request(OP_FLUSH, FIELD_BITS'($urandom()));
            need_config = 1'b1;
         end else if (roll == 8) begin
            stream_image(cur_w, cur_h, 0, cur_w, 1'b1);
            need_config = 1'b1;
         end else begin
            repeat ($urandom_range(1, 10))
               issue_request(op_type'(1'($urandom_range(0, 1))), FIELD_BITS'($urandom()));
            need_config = 1'b1;
         end
      end

      drain_filter();
      if (fail_count == 0 && pending_count == 0)
         $display("PASS depth_outlier_neighbour_filter_unit");
      else
         $display("FAIL depth_outlier_neighbour_filter_unit");
      $finish;
   end

endmodule
